[rtl/ste_pkg.sv]
// ----------------------------------------------------------------------------
// ste_pkg
// shared types and codes of the series transcendental unit
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_ITER,
        S_ACC,
        S_FIN,
        S_DONE
    } state_t;

    // what a finished multiply or divide feeds
    typedef enum logic [2:0] {
        STEP_Z,
        STEP_Z2,
        STEP_X2,
        STEP_TERM,
        STEP_POW
    } step_t;

    typedef enum logic [1:0] {
        K_EXP,
        K_LN,
        K_SIN,
        K_COS
    } kind_t;

    localparam logic [2:0] CMD_EXP = 3'd0;
    localparam logic [2:0] CMD_LN  = 3'd1;
    localparam logic [2:0] CMD_SIN = 3'd2;
    localparam logic [2:0] CMD_COS = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_OVF    = 2'd1;
    localparam logic [1:0] STATUS_DOMAIN = 2'd2;

    localparam logic [1:0] REG_EXP_TERMS  = 2'd0;
    localparam logic [1:0] REG_LOG_TERMS  = 2'd1;
    localparam logic [1:0] REG_TRIG_TERMS = 2'd2;

    localparam logic [7:0] EXP_TERMS_RST  = 8'd150;
    localparam logic [7:0] LOG_TERMS_RST  = 8'd150;
    localparam logic [5:0] TRIG_TERMS_RST = 6'd20;

endpackage

`default_nettype wire

[rtl/series_transcendental_unit.sv]
// ----------------------------------------------------------------------------
// series_transcendental_unit
// exp, ln, sin, cos and pow of fixed-point operands by truncated series
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   s_command, s_operand_a, s_operand_b
// m_        out        m_valid / m_ready   m_result_value, m_status_code
// cfg_      in         cfg_wr_en           cfg_addr, cfg_wdata
//
// one shared shift-add multiplier (WORD_BITS steps) and one restoring divider
// (max(WORD_BITS, 32 + FRAC_BITS) steps) do all the work; each series term
// costs one multiply and one divide, and a word runs until its term count is
// reached or a term comes out zero (pow runs an ln series, then an exp series).
// s_ready is high only while no word is in work; a finished word waits in
// the output register and the next word can be taken meanwhile.
// aresetn is synchronous, active low, and restores the term counts.
// ----------------------------------------------------------------------------
`default_nettype none

module series_transcendental_unit
    import ste_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [2:0]         s_command,
    input  wire  signed [31:0] s_operand_a,
    input  wire  signed [31:0] s_operand_b,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_result_value,
    output logic [1:0]         m_status_code,
    input  wire                cfg_wr_en,
    input  wire  [1:0]         cfg_addr,
    input  wire  [7:0]         cfg_wdata
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int DW = (WORD_BITS > 32 + FRAC_BITS) ? WORD_BITS : 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int XW = (WORD_BITS > 32) ? WORD_BITS : 33;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [31:0] ONE32 = 32'd1 << F;
    localparam logic signed [XW-1:0] R32MAX = XW'(signed'(32'h7fff_ffff));
    localparam logic signed [XW-1:0] R32MIN = XW'(signed'(32'h8000_0000));
    localparam logic [CW-1:0] MUL_STEPS = CW'(W);
    localparam logic [CW-1:0] DIV_STEPS = CW'(DW);

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    // saturating add, overflow flag on top
    function automatic logic [W:0] addw(input logic signed [W-1:0] x,
                                        input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1]) begin
            addw = {1'b1, (s[W] ? WMIN : WMAX)};
        end else begin
            addw = {1'b0, s[W-1:0]};
        end
    endfunction

    // floor shift of the signed product (magnitude rounded up when negative), sign and saturation
    function automatic logic [W:0] mul_finish(input logic [PW-1:0] p,
                                              input logic neg);
        logic [PW-1:0]   ps;
        logic [PW-F-1:0] m;
        logic [PW-F-1:0] lim;
        ps  = p + (neg ? {{(PW-F){1'b0}}, {F{1'b1}}} : {PW{1'b0}});
        m   = ps[PW-1:F];
        lim = neg ? {{(PW-F-W){1'b0}}, 1'b1, {(W-1){1'b0}}}
                  : {{(PW-F-W){1'b0}}, 1'b0, {(W-1){1'b1}}};
        if (m > lim) begin
            mul_finish = {1'b1, (neg ? WMIN : WMAX)};
        end else begin
            mul_finish = {1'b0, (neg ? W'(-m[W-1:0]) : m[W-1:0])};
        end
    endfunction

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    kind_t  kind_reg, kind_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic signed [31:0] araw_reg, araw_next;
    logic signed [31:0] braw_reg, braw_next;
    logic signed [W-1:0] b_reg, b_next;
    logic signed [W-1:0] t_reg, t_next;
    logic signed [W-1:0] mult_reg, mult_next;
    logic signed [W-1:0] sum_reg, sum_next;
    logic signed [W-1:0] term_reg, term_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] n_reg, n_next;
    logic ov_reg, ov_next;
    logic dom_reg, dom_next;
    logic [W-1:0] mul_a_reg, mul_a_next;
    logic [W-1:0] mul_hi_reg, mul_hi_next;
    logic [W-1:0] mul_lo_reg, mul_lo_next;
    logic mul_neg_reg, mul_neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic div_neg_reg, div_neg_next;
    logic m_valid_reg, m_valid_next;
    logic signed [31:0] m_result_value_reg, m_result_value_next;
    logic [1:0] m_status_code_reg, m_status_code_next;
    logic [7:0] exp_cnt_reg, exp_cnt_next;
    logic [7:0] log_cnt_reg, log_cnt_next;
    logic [5:0] trig_cnt_reg, trig_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= STEP_Z;
            kind_reg     <= K_EXP;
            ov_reg       <= 1'b0;
            dom_reg      <= 1'b0;
            cnt_reg      <= '0;
            i_reg        <= '0;
            n_reg        <= '0;
            m_valid_reg  <= 1'b0;
            exp_cnt_reg  <= EXP_TERMS_RST;
            log_cnt_reg  <= LOG_TERMS_RST;
            trig_cnt_reg <= TRIG_TERMS_RST;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            kind_reg     <= kind_next;
            ov_reg       <= ov_next;
            dom_reg      <= dom_next;
            cnt_reg      <= cnt_next;
            i_reg        <= i_next;
            n_reg        <= n_next;
            m_valid_reg  <= m_valid_next;
            exp_cnt_reg  <= exp_cnt_next;
            log_cnt_reg  <= log_cnt_next;
            trig_cnt_reg <= trig_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg            <= cmd_next;
        araw_reg           <= araw_next;
        braw_reg           <= braw_next;
        b_reg              <= b_next;
        t_reg              <= t_next;
        mult_reg           <= mult_next;
        sum_reg            <= sum_next;
        term_reg           <= term_next;
        mul_a_reg          <= mul_a_next;
        mul_hi_reg         <= mul_hi_next;
        mul_lo_reg         <= mul_lo_next;
        mul_neg_reg        <= mul_neg_next;
        rem_reg            <= rem_next;
        quo_reg            <= quo_next;
        dvs_reg            <= dvs_next;
        div_neg_reg        <= div_neg_next;
        m_result_value_reg <= m_result_value_next;
        m_status_code_reg  <= m_status_code_next;
    end

    always_comb begin
        logic signed [XW-1:0] ax;
        logic signed [XW-1:0] bx;
        logic signed [XW-1:0] rx;
        logic signed [W-1:0]  a_cl;
        logic signed [W-1:0]  b_cl;
        logic signed [W-1:0]  mq;
        logic signed [W-1:0]  dq;
        logic signed [W-1:0]  lnv;
        logic [W:0]           wtmp;
        logic [W:0]           msum;
        logic [32:0]          rsh;
        logic signed [32:0]   zn;
        logic [31:0]          zmag;
        logic [8:0]           i2;
        logic [17:0]          dtrig;
        logic                 start_mul;
        logic signed [W-1:0]  mul_x;
        logic signed [W-1:0]  mul_y;
        logic                 start_div;
        logic [DW-1:0]        div_val;
        logic                 div_sign;
        logic [31:0]          div_by;

        state_next          = state_reg;
        step_next           = step_reg;
        kind_next           = kind_reg;
        cmd_next            = cmd_reg;
        araw_next           = araw_reg;
        braw_next           = braw_reg;
        b_next              = b_reg;
        t_next              = t_reg;
        mult_next           = mult_reg;
        sum_next            = sum_reg;
        term_next           = term_reg;
        i_next              = i_reg;
        n_next              = n_reg;
        ov_next             = ov_reg;
        dom_next            = dom_reg;
        mul_a_next          = mul_a_reg;
        mul_hi_next         = mul_hi_reg;
        mul_lo_next         = mul_lo_reg;
        mul_neg_next        = mul_neg_reg;
        cnt_next            = cnt_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        dvs_next            = dvs_reg;
        div_neg_next        = div_neg_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_result_value_next = m_result_value_reg;
        m_status_code_next  = m_status_code_reg;
        exp_cnt_next        = exp_cnt_reg;
        log_cnt_next        = log_cnt_reg;
        trig_cnt_next       = trig_cnt_reg;

        start_mul = 1'b0;
        mul_x     = '0;
        mul_y     = '0;
        start_div = 1'b0;
        div_val   = '0;
        div_sign  = 1'b0;
        div_by    = '0;
        a_cl      = '0;
        b_cl      = '0;
        lnv       = '0;
        zn        = '0;
        zmag      = '0;

        ax = XW'(araw_reg);
        bx = XW'(braw_reg);
        rx = XW'(sum_reg);
        mq = '0;
        dq = div_neg_reg ? W'(-quo_reg[W-1:0]) : quo_reg[W-1:0];
        msum = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_a_reg} : {(W+1){1'b0}});
        rsh  = {rem_reg, quo_reg[DW-1]};
        i2   = {i_reg, 1'b0};
        dtrig = (kind_reg == K_COS) ? 18'(i2 - 9'd1) * 18'(i2) : 18'(i2) * 18'(i2 + 9'd1);
        wtmp = '0;

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EXP_TERMS:  exp_cnt_next  = cfg_wdata;
                REG_LOG_TERMS:  log_cnt_next  = cfg_wdata;
                REG_TRIG_TERMS: trig_cnt_next = cfg_wdata[5:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    araw_next  = s_operand_a;
                    braw_next  = s_operand_b;
                    ov_next    = 1'b0;
                    dom_next   = 1'b0;
                    state_next = S_SETUP;
                end
            end

            S_SETUP: begin
                if (ax > XW'(WMAX)) begin
                    a_cl = WMAX;
                    ov_next = 1'b1;
                end else if (ax < XW'(WMIN)) begin
                    a_cl = WMIN;
                    ov_next = 1'b1;
                end else begin
                    a_cl = ax[W-1:0];
                end
                if (bx > XW'(WMAX)) begin
                    b_cl = WMAX;
                    ov_next = 1'b1;
                end else if (bx < XW'(WMIN)) begin
                    b_cl = WMIN;
                    ov_next = 1'b1;
                end else begin
                    b_cl = bx[W-1:0];
                end
                b_next   = b_cl;
                sum_next = '0;
                i_next   = '0;
                case (cmd_reg)
                    CMD_EXP: begin
                        kind_next  = K_EXP;
                        t_next     = ONE;
                        mult_next  = a_cl;
                        n_next     = exp_cnt_reg;
                        state_next = S_ITER;
                    end
                    CMD_LN, CMD_POW: begin
                        if (araw_reg <= 32'sd0) begin
                            dom_next   = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            kind_next = K_LN;
                            n_next    = log_cnt_reg;
                            zn        = {araw_reg[31], araw_reg} - 33'(ONE32);
                            zmag      = zn[32] ? 32'(-zn) : zn[31:0];
                            start_div = 1'b1;
                            div_val   = DW'(zmag) << F;
                            div_sign  = zn[32];
                            div_by    = araw_reg + ONE32;
                            step_next = STEP_Z;
                        end
                    end
                    CMD_SIN, CMD_COS: begin
                        kind_next = (cmd_reg == CMD_COS) ? K_COS : K_SIN;
                        t_next    = (cmd_reg == CMD_COS) ? ONE : a_cl;
                        n_next    = {2'b00, trig_cnt_reg};
                        start_mul = 1'b1;
                        mul_x     = a_cl;
                        mul_y     = a_cl;
                        step_next = STEP_X2;
                    end
                    default: begin
                        dom_next   = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_MUL: begin
                if (cnt_reg != MUL_STEPS) begin
                    mul_hi_next = msum[W:1];
                    mul_lo_next = {msum[0], mul_lo_reg[W-1:1]};
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    wtmp = mul_finish({mul_hi_reg, mul_lo_reg}, mul_neg_reg);
                    mq   = wtmp[W-1:0];
                    if (wtmp[W]) begin
                        ov_next = 1'b1;
                    end
                    case (step_reg)
                        STEP_Z2, STEP_X2: begin
                            mult_next  = mq;
                            state_next = S_ITER;
                        end
                        STEP_TERM: begin
                            if (kind_reg == K_LN) begin
                                t_next = mq;
                            end
                            start_div = 1'b1;
                            div_val   = DW'(mag(mq));
                            div_sign  = mq[W-1];
                            case (kind_reg)
                                K_EXP:   div_by = 32'(i_reg);
                                K_LN:    div_by = 32'(i2) + 32'd1;
                                default: div_by = 32'(dtrig);
                            endcase
                        end
                        STEP_POW: begin
                            kind_next  = K_EXP;
                            t_next     = ONE;
                            mult_next  = mq;
                            sum_next   = '0;
                            i_next     = '0;
                            n_next     = exp_cnt_reg;
                            state_next = S_ITER;
                        end
                        default: state_next = S_ITER;
                    endcase
                end
            end

            S_DIV: begin
                if (cnt_reg != DIV_STEPS) begin
                    if (rsh >= {1'b0, dvs_reg}) begin
                        rem_next = 32'(rsh - {1'b0, dvs_reg});
                        quo_next = {quo_reg[DW-2:0], 1'b1};
                    end else begin
                        rem_next = rsh[31:0];
                        quo_next = {quo_reg[DW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    if (step_reg == STEP_Z) begin
                        t_next    = dq;
                        start_mul = 1'b1;
                        mul_x     = dq;
                        mul_y     = dq;
                        step_next = STEP_Z2;
                    end else begin
                        case (kind_reg)
                            K_LN: begin
                                term_next = dq;
                            end
                            K_EXP: begin
                                t_next    = dq;
                                term_next = dq;
                            end
                            default: begin
                                if (dq == WMIN) begin
                                    ov_next   = 1'b1;
                                    t_next    = WMAX;
                                    term_next = WMAX;
                                end else begin
                                    t_next    = -dq;
                                    term_next = -dq;
                                end
                            end
                        endcase
                        state_next = S_ACC;
                    end
                end
            end

            S_ITER: begin
                if (i_reg == n_reg) begin
                    state_next = S_FIN;
                end else if (i_reg == 8'd0) begin
                    term_next  = t_reg;
                    state_next = S_ACC;
                end else begin
                    start_mul = 1'b1;
                    mul_x     = t_reg;
                    mul_y     = mult_reg;
                    step_next = STEP_TERM;
                end
            end

            S_ACC: begin
                if (term_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    wtmp     = addw(sum_reg, term_reg);
                    sum_next = wtmp[W-1:0];
                    if (wtmp[W]) begin
                        ov_next = 1'b1;
                    end
                    i_next     = i_reg + 8'd1;
                    state_next = S_ITER;
                end
            end

            S_FIN: begin
                if (kind_reg == K_LN) begin
                    wtmp = addw(sum_reg, sum_reg);
                    lnv  = wtmp[W-1:0];
                    if (wtmp[W]) begin
                        ov_next = 1'b1;
                    end
                    if (cmd_reg == CMD_POW) begin
                        start_mul = 1'b1;
                        mul_x     = b_reg;
                        mul_y     = lnv;
                        step_next = STEP_POW;
                    end else begin
                        sum_next   = lnv;
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (dom_reg) begin
                        m_result_value_next = '0;
                        m_status_code_next  = STATUS_DOMAIN;
                    end else if (rx > R32MAX) begin
                        m_result_value_next = 32'sh7fff_ffff;
                        m_status_code_next  = STATUS_OVF;
                    end else if (rx < R32MIN) begin
                        m_result_value_next = 32'sh8000_0000;
                        m_status_code_next  = STATUS_OVF;
                    end else begin
                        m_result_value_next = rx[31:0];
                        m_status_code_next  = ov_reg ? STATUS_OVF : STATUS_OK;
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (start_mul) begin
            mul_a_next   = mag(mul_x);
            mul_lo_next  = mag(mul_y);
            mul_hi_next  = '0;
            mul_neg_next = mul_x[W-1] != mul_y[W-1];
            cnt_next     = '0;
            state_next   = S_MUL;
        end
        if (start_div) begin
            quo_next     = div_val;
            rem_next     = '0;
            dvs_next     = div_by;
            div_neg_next = div_sign;
            cnt_next     = '0;
            state_next   = S_DIV;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_status_code  = m_status_code_reg;

endmodule

`default_nettype wire
